@@ hw/rtl/hmns_pkg.sv @@
`default_nettype none

package hmns_pkg;

    localparam int MAX_GRID = 1024;        // largest grid_size the buffers hold
    localparam int GRID_W   = 11;          // grid_size / counter width
    localparam int ROW_W    = 10;          // vertex_row width
    localparam int H_W      = 16;          // height sample width
    localparam int SP_W     = 16;          // spacing width
    localparam int DIFF_W   = H_W + 1;     // signed height difference
    localparam int SQ_W     = 2 * H_W;     // one squared term
    localparam int SUM_W    = SQ_W + 2;    // sum of three squares
    localparam int RAD_W    = SUM_W + 16;  // sum scaled by 2^16 for the root
    localparam int ROOT_W   = RAD_W / 2;   // root width
    localparam int Q_W      = 16;          // quotient bits
    localparam int FRAC_SH  = 23;          // component scale shift
    localparam int ADDR_W   = 3;           // APB byte address width
    localparam int DATA_W   = 32;
    localparam int MIN_GRID = 4;

    typedef enum logic {
        REG_GRID_SIZE = 1'b0,
        REG_SPACING   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [H_W-1:0] height;
        logic           frame_start;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic [14:0]        normal_y;
        logic signed [15:0] normal_z;
        logic [ROW_W-1:0]   vertex_row;
        logic [GRID_W-1:0]  vertex_col;
        logic               on_edge;
    } normal_t;

    // position info of one request, carried down the pipe
    typedef struct packed {
        logic              emit;
        logic              on_edge;
        logic [ROW_W-1:0]  vertex_row;
        logic [GRID_W-1:0] vertex_col;
    } pos_t;

    // everything the root and divide stages pass along untouched
    typedef struct packed {
        pos_t           pos;
        logic           zero;
        logic           neg_x;
        logic           neg_z;
        logic [H_W-1:0] mag_x;
        logic [H_W-1:0] mag_y;
        logic [H_W-1:0] mag_z;
    } tag_t;

endpackage

`default_nettype wire

@@ hw/rtl/hmns_sqrt.sv @@
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module hmns_sqrt (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [hmns_pkg::RAD_W-1:0]     radicand,
    input  wire hmns_pkg::tag_t                 in_tag,
    output logic                                out_valid,
    output logic [hmns_pkg::ROOT_W-1:0]         root,
    output hmns_pkg::tag_t                      out_tag
);

    localparam int N  = hmns_pkg::ROOT_W;
    localparam int RW = hmns_pkg::RAD_W + 1;

    logic [RW-1:0]        rem_reg   [N];
    logic [N-1:0]         root_reg  [N];
    hmns_pkg::tag_t       tag_reg   [N];
    logic                 valid_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam int B = N - 1 - k;   // root bit decided here
        logic [RW-1:0]  rem_in;
        logic [N-1:0]   root_in;
        hmns_pkg::tag_t tag_in;
        logic           valid_in;
        logic [RW-1:0]  trial;
        logic           fits;
        logic [RW-1:0]  rem_next;
        logic [N-1:0]   root_next;

        if (k == 0)
        begin : g_first
            assign rem_in   = RW'(radicand);
            assign root_in  = '0;
            assign tag_in   = in_tag;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign tag_in   = tag_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign trial     = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));
        assign fits      = (rem_in >= trial);
        assign rem_next  = fits ? (rem_in - trial) : rem_in;
        assign root_next = fits ? (root_in | (N'(1) << B)) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

`default_nettype wire

@@ hw/rtl/hmns_div.sv @@
`default_nettype none

// Three-lane pipelined divider: q = (mag * 2^23 + m/2) / m, one quotient
// bit per stage. Quotient is known to fit in Q_W bits.
module hmns_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [hmns_pkg::ROOT_W-1:0]    divisor,
    input  wire hmns_pkg::tag_t                 in_tag,
    output logic                                out_valid,
    output logic [hmns_pkg::Q_W-1:0]            quot_x,
    output logic [hmns_pkg::Q_W-1:0]            quot_y,
    output logic [hmns_pkg::Q_W-1:0]            quot_z,
    output hmns_pkg::tag_t                      out_tag
);

    localparam int MW    = hmns_pkg::ROOT_W;
    localparam int QW    = hmns_pkg::Q_W;
    localparam int DW    = hmns_pkg::H_W + hmns_pkg::FRAC_SH + 1;
    localparam int NS    = QW + 1;   // init stage plus one per bit
    localparam int LANES = 3;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [QW-1:0] bits;   // dividend bits still to shift in, quotient shifted in below
    } lane_t;

    function automatic lane_t div_step(lane_t l, logic [MW-1:0] m);
        logic [MW:0] t;
        logic        ge;
        lane_t       r;
        t      = {l.rem, l.bits[QW-1]};
        ge     = (t >= {1'b0, m});
        r.rem  = ge ? MW'(t - {1'b0, m}) : t[MW-1:0];
        r.bits = {l.bits[QW-2:0], ge};
        return r;
    endfunction

    function automatic lane_t div_init(logic [hmns_pkg::H_W-1:0] mag, logic [MW-1:0] m);
        logic [DW-1:0] d;
        lane_t         r;
        d      = DW'({mag, {hmns_pkg::FRAC_SH{1'b0}}}) + DW'(m >> 1);
        r.rem  = MW'(d[DW-1:QW]);
        r.bits = d[QW-1:0];
        return r;
    endfunction

    lane_t          lane_reg  [NS][LANES];
    logic [MW-1:0]  m_reg     [NS];
    hmns_pkg::tag_t tag_reg   [NS];
    logic           valid_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        lane_t          lane_next [LANES];
        logic [MW-1:0]  m_in;
        hmns_pkg::tag_t tag_in;
        logic           valid_in;

        if (k == 0)
        begin : g_first
            assign m_in         = divisor;
            assign tag_in       = in_tag;
            assign valid_in     = in_valid;
            assign lane_next[0] = div_init(in_tag.mag_x, divisor);
            assign lane_next[1] = div_init(in_tag.mag_y, divisor);
            assign lane_next[2] = div_init(in_tag.mag_z, divisor);
        end
        else
        begin : g_rest
            assign m_in     = m_reg[k-1];
            assign tag_in   = tag_reg[k-1];
            assign valid_in = valid_reg[k-1];
            for (genvar j = 0; j < LANES; j++)
            begin : g_lane
                assign lane_next[j] = div_step(lane_reg[k-1][j], m_reg[k-1]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]   <= m_in;
                tag_reg[k] <= tag_in;
                for (int j = 0; j < LANES; j++)
                begin
                    lane_reg[k][j] <= lane_next[j];
                end
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot_x    = lane_reg[NS-1][0].bits;
    assign quot_y    = lane_reg[NS-1][1].bits;
    assign quot_z    = lane_reg[NS-1][2].bits;
    assign out_tag   = tag_reg[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/heightmap_normal_stencil.sv @@
// Heightmap normal stencil: unit vertex normals by central differences.
// Requests on the sample channel carry one height per vertex of a square
// grid of (grid_size+1)^2 vertices, row-major; frame_start restarts the
// row and column counters. For each sample in row r >= 1 the block sends
// one request on the normal channel for vertex (r-1, c); edge vertices
// carry on_edge and a zero normal; samples of row 0 send nothing.
// Both channels: valid/stall, a request moves on an edge with valid high
// and stall low. One sample is taken every cycle while the output is not
// stalled; on its way to a normal a sample passes the line-buffer read,
// difference, squares, sum, 25 root stages, 17 divide stages and the
// output register. The root and the divider make up most of the pipe depth.
// A stalled output freezes the whole pipe, so sample_stall follows a
// held, full output register; nothing is dropped or repeated.
// Reset clears the counters, the left-neighbor register and all valid bits;
// line buffer contents are undefined until a row has been written. The user
// must write grid_size and spacing over APB only while idle; not enforced.
`default_nettype none

module heightmap_normal_stencil (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hmns_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [hmns_pkg::DATA_W-1:0]       pwdata,
    output logic [hmns_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire hmns_pkg::sample_t                 sample,
    output logic                                   normal_valid,
    input  wire logic                              normal_stall,
    output hmns_pkg::normal_t                      normal
);

    localparam int MAX_GRID = hmns_pkg::MAX_GRID;
    localparam int DEPTH  = MAX_GRID + 1;
    localparam int AW     = $clog2(MAX_GRID + 1);
    localparam int GW     = hmns_pkg::GRID_W;
    localparam int HW     = hmns_pkg::H_W;
    localparam int DFW    = hmns_pkg::DIFF_W;
    localparam int GS_CAP = (MAX_GRID > 2047) ? 2047 : MAX_GRID;

    // ---------------- configuration registers ----------------
    logic [GW-1:0]              grid_size_reg;
    logic [hmns_pkg::SP_W-1:0]  spacing_reg;
    hmns_pkg::reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = hmns_pkg::reg_idx_t'(paddr[hmns_pkg::ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GW'(64);
            spacing_reg   <= 16'd4096;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                hmns_pkg::REG_GRID_SIZE: grid_size_reg <= pwdata[GW-1:0];
                hmns_pkg::REG_SPACING:   spacing_reg   <= pwdata[hmns_pkg::SP_W-1:0];
                default:                 spacing_reg   <= spacing_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hmns_pkg::REG_GRID_SIZE: prdata = hmns_pkg::DATA_W'(grid_size_reg);
            hmns_pkg::REG_SPACING:   prdata = hmns_pkg::DATA_W'(spacing_reg);
            default:                 prdata = '0;
        endcase
    end

    // grid size as used: clamped to [MIN_GRID, MAX_GRID]
    logic [GW-1:0] gs_eff;
    always_comb
    begin
        if (grid_size_reg < GW'(hmns_pkg::MIN_GRID))
            gs_eff = GW'(hmns_pkg::MIN_GRID);
        else if (32'(grid_size_reg) > GS_CAP)
            gs_eff = GW'(GS_CAP);
        else
            gs_eff = grid_size_reg;
    end

    // ---------------- flow control ----------------
    // Single global advance: the pipe moves unless the output is held.
    logic normal_valid_reg;
    logic adv;
    logic accept;

    assign adv          = !(normal_valid_reg && normal_stall);
    assign sample_stall = !adv;
    assign accept       = sample_valid && adv;

    // ---------------- position counters ----------------
    logic [GW-1:0] row_count_reg, col_count_reg;
    logic [GW-1:0] r_cur, c_cur;
    logic [GW-1:0] row_count_next, col_count_next;
    hmns_pkg::pos_t pos_cur;

    assign r_cur = sample.frame_start ? '0 : row_count_reg;
    assign c_cur = sample.frame_start ? '0 : col_count_reg;

    always_comb
    begin
        pos_cur.emit       = (r_cur != '0) && (r_cur <= gs_eff);
        pos_cur.on_edge    = (r_cur == GW'(1)) || (c_cur == '0) || (c_cur >= gs_eff);
        pos_cur.vertex_row = hmns_pkg::ROW_W'(r_cur - GW'(1));
        pos_cur.vertex_col = c_cur;
        if (c_cur >= gs_eff)
        begin
            // end of row; after the last row the counter wraps to the top
            col_count_next = '0;
            row_count_next = (r_cur >= gs_eff) ? '0 : r_cur + GW'(1);
        end
        else
        begin
            col_count_next = c_cur + GW'(1);
            row_count_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (accept)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // ---------------- line buffer ----------------
    // One word per column: {older row, middle row}. Read at c (both rows)
    // and c+1 (middle row, right neighbor); written back from stage 1 with
    // {old middle, new height}. The write of the request just ahead is
    // forwarded into the read so back-to-back requests see it.
    logic [2*HW-1:0] line_mem [DEPTH];
    logic [AW-1:0]   addr_a, addr_b;
    logic [2*HW-1:0] rd_a_reg, rd_b_reg;
    logic [2*HW-1:0] wdata;
    logic            mem_we;

    logic            s1_valid_reg;
    logic [HW-1:0]   s1_height_reg;
    logic [AW-1:0]   s1_addr_reg;
    hmns_pkg::pos_t  s1_pos_reg;
    logic [HW-1:0]   s1_mid, s1_older, s1_right;
    logic [HW-1:0]   prev_mid_reg;

    assign addr_a = AW'(c_cur);
    assign addr_b = (32'(c_cur) >= MAX_GRID) ? addr_a : addr_a + AW'(1);

    assign s1_mid   = rd_a_reg[HW-1:0];
    assign s1_older = rd_a_reg[2*HW-1:HW];
    assign s1_right = rd_b_reg[HW-1:0];
    assign mem_we   = adv && s1_valid_reg;
    assign wdata    = {s1_mid, s1_height_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[s1_addr_reg] <= wdata;
        end
        if (adv)
        begin
            rd_a_reg <= (mem_we && (s1_addr_reg == addr_a)) ? wdata : line_mem[addr_a];
            rd_b_reg <= (mem_we && (s1_addr_reg == addr_b)) ? wdata : line_mem[addr_b];
        end
    end

    // left neighbor: middle-row sample read by the previous request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mid_reg <= '0;
        end
        else if (mem_we)
        begin
            prev_mid_reg <= s1_mid;
        end
    end

    // ---------------- stage 1: request registered, buffer read ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_height_reg <= sample.height;
            s1_addr_reg   <= addr_a;
            s1_pos_reg    <= pos_cur;
        end
    end

    // ---------------- stage 2: differences ----------------
    logic                  s2_valid_reg;
    logic signed [DFW-1:0] s2_hx_reg, s2_hz_reg;
    hmns_pkg::pos_t        s2_pos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_hx_reg  <= $signed({1'b0, s1_height_reg}) - $signed({1'b0, s1_older});
            s2_hz_reg  <= $signed({1'b0, s1_right}) - $signed({1'b0, prev_mid_reg});
            s2_pos_reg <= s1_pos_reg;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic                       s3_valid_reg;
    logic [hmns_pkg::SQ_W-1:0]  s3_sqx_reg, s3_sqz_reg, s3_sqs_reg;
    logic                       s3_neg_x_reg, s3_neg_z_reg;
    logic [HW-1:0]              s3_mag_x_reg, s3_mag_z_reg;
    hmns_pkg::pos_t             s3_pos_reg;
    logic signed [2*DFW-1:0]    prod_x, prod_z;
    logic signed [DFW-1:0]      abs_x, abs_z;

    assign prod_x = s2_hx_reg * s2_hx_reg;
    assign prod_z = s2_hz_reg * s2_hz_reg;
    assign abs_x  = s2_hx_reg[DFW-1] ? -s2_hx_reg : s2_hx_reg;
    assign abs_z  = s2_hz_reg[DFW-1] ? -s2_hz_reg : s2_hz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sqx_reg   <= prod_x[hmns_pkg::SQ_W-1:0];
            s3_sqz_reg   <= prod_z[hmns_pkg::SQ_W-1:0];
            s3_sqs_reg   <= spacing_reg * spacing_reg;
            s3_neg_x_reg <= s2_hx_reg[DFW-1];
            s3_neg_z_reg <= s2_hz_reg[DFW-1];
            s3_mag_x_reg <= abs_x[HW-1:0];
            s3_mag_z_reg <= abs_z[HW-1:0];
            s3_pos_reg   <= s2_pos_reg;
        end
    end

    // ---------------- stage 4: sum of squares ----------------
    logic                        s4_valid_reg;
    logic [hmns_pkg::SUM_W-1:0]  s4_sum_reg;
    hmns_pkg::tag_t              s4_tag_reg;
    logic [hmns_pkg::SUM_W-1:0]  sum_next;

    assign sum_next = hmns_pkg::SUM_W'(s3_sqx_reg) + hmns_pkg::SUM_W'(s3_sqz_reg)
                    + hmns_pkg::SUM_W'(s3_sqs_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sum_reg       <= sum_next;
            s4_tag_reg.pos   <= s3_pos_reg;
            s4_tag_reg.zero  <= (sum_next == '0);
            s4_tag_reg.neg_x <= s3_neg_x_reg;
            s4_tag_reg.neg_z <= s3_neg_z_reg;
            s4_tag_reg.mag_x <= s3_mag_x_reg;
            s4_tag_reg.mag_y <= spacing_reg;
            s4_tag_reg.mag_z <= s3_mag_z_reg;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- vector length: m = isqrt(S * 2^16) ----------------
    logic                         sq_valid;
    logic [hmns_pkg::ROOT_W-1:0]  sq_root;
    hmns_pkg::tag_t               sq_tag;

    hmns_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .radicand  ({s4_sum_reg, 16'h0000}),
        .in_tag    (s4_tag_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // ---------------- components: |v| * 2^23 / m, rounded ----------------
    logic                      dv_valid;
    logic [hmns_pkg::Q_W-1:0]  q_x, q_y, q_z;
    hmns_pkg::tag_t            dv_tag;

    hmns_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .divisor   (sq_root),
        .in_tag    (sq_tag),
        .out_valid (dv_valid),
        .quot_x    (q_x),
        .quot_y    (q_y),
        .quot_z    (q_z),
        .out_tag   (dv_tag)
    );

    // ---------------- output register ----------------
    // Negative components may reach -1.0; positive ones stop at 32767.
    function automatic logic [15:0] sat_comp(logic [15:0] q, logic neg);
        logic [15:0] lim;
        logic [15:0] mag;
        lim = neg ? 16'h8000 : 16'h7FFF;
        mag = (q > lim) ? lim : q;
        return neg ? (16'h0000 - mag) : mag;
    endfunction

    hmns_pkg::normal_t normal_reg;
    hmns_pkg::normal_t normal_next;
    logic [15:0]       y_full;

    assign y_full = sat_comp(q_y, 1'b0);

    always_comb
    begin
        normal_next.vertex_row = dv_tag.pos.vertex_row;
        normal_next.vertex_col = dv_tag.pos.vertex_col;
        normal_next.on_edge    = dv_tag.pos.on_edge;
        if (dv_tag.pos.on_edge)
        begin
            normal_next.normal_x = '0;
            normal_next.normal_y = '0;
            normal_next.normal_z = '0;
        end
        else if (dv_tag.zero)
        begin
            // flat ground with zero spacing: straight up
            normal_next.normal_x = '0;
            normal_next.normal_y = 15'h7FFF;
            normal_next.normal_z = '0;
        end
        else
        begin
            normal_next.normal_x = $signed(sat_comp(q_x, dv_tag.neg_x));
            normal_next.normal_y = y_full[14:0];
            normal_next.normal_z = $signed(sat_comp(q_z, dv_tag.neg_z));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            normal_valid_reg <= dv_valid && dv_tag.pos.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            normal_reg <= normal_next;
        end
    end

    assign normal_valid = normal_valid_reg;
    assign normal       = normal_reg;

    // ---------------- assertions ----------------
    a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        normal_valid && normal.on_edge |->
            normal.normal_x == 16'sd0 && normal.normal_y == 15'd0 && normal.normal_z == 16'sd0)
        else $error("edge vertex with nonzero normal");

    a_inner_pos: assert property (@(posedge clk) disable iff (!rst_n)
        normal_valid && !normal.on_edge |->
            normal.vertex_row != '0 && normal.vertex_col != '0)
        else $error("inner vertex on row or column zero");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid_reg) && $stable(row_count_reg) && $stable(col_count_reg))
        else $error("pipe moved while output held");

endmodule

`default_nettype wire
